// File: rtl/core/tcbs_pkg.sv
// tcbs_pkg: shared constants, types and helpers for the text chunk boundary splitter
// no dependencies; used by every other file of the block

package tcbs_pkg;

  // default values for the top level parameters
  localparam int LOOKBACK_WINDOW_DEF = 200;
  localparam int DEPTH_BITS_DEF      = 16;
  localparam int POSITION_BITS_DEF   = 32;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int TARGET_W = 16;
  localparam int START_W  = 32;
  localparam int LEN_W    = 18;

  // configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SPLIT_MODE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_TARGET = 1'b1;
  localparam logic [TARGET_W-1:0]  TARGET_RESET     = 16'd512;

  // result queue; depth must be a power of two and at least MAX_RESULTS
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;

  // characters that steer the cuts
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic                split_mode;
    logic [TARGET_W-1:0] chunk_target;
  } cfg_t;

  typedef struct packed {
    logic [START_W-1:0] chunk_start;
    logic [LEN_W-1:0]   chunk_length;
    logic               final_chunk;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0] vld;
    result_t [MAX_RESULTS-1:0] res;
  } result_set_t;

  typedef struct packed {
    logic stage_valid;
    logic advance;
  } stage_status_t;

  function automatic logic is_end_mark(input logic [BYTE_W-1:0] c);
    return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUEST);
  endfunction

endpackage

// File: rtl/core/tcbs_if.sv
// tcbs_if: valid/ready channel interfaces for text bytes in and chunk results out
// depends on tcbs_pkg for field widths

interface tcbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcbs_pkg::BYTE_W-1:0] text_byte;
  logic                        end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tcbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcbs_pkg::START_W-1:0] chunk_start;
  logic [tcbs_pkg::LEN_W-1:0]   chunk_length;
  logic                         final_chunk;
  logic                         last_of_run;

  modport source(output valid, output chunk_start, output chunk_length,
                 output final_chunk, output last_of_run, input ready);
  modport sink(input valid, input chunk_start, input chunk_length,
               input final_chunk, input last_of_run, output ready);
endinterface

// File: rtl/core/tcbs_cfg_regs.sv
// tcbs_cfg_regs: apb-style register file holding split mode and target chunk size
// depends on tcbs_pkg

module tcbs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcbs_pkg::ADDR_W-1:0]   paddr,
  input  logic [tcbs_pkg::DATA_W-1:0]   pwdata,
  output logic [tcbs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tcbs_pkg::cfg_t                cfg
);

  logic                              mode_r;
  logic [tcbs_pkg::TARGET_W-1:0]     target_r;
  logic [tcbs_pkg::REG_IDX_W-1:0]    idx;
  logic                              wr_en;

  assign idx    = paddr[tcbs_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      target_r <= tcbs_pkg::TARGET_RESET;
    end else if (wr_en) begin
      unique case (idx)
        tcbs_pkg::REG_SPLIT_MODE:   mode_r   <= pwdata[0];
        tcbs_pkg::REG_CHUNK_TARGET: target_r <= pwdata[tcbs_pkg::TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tcbs_pkg::REG_SPLIT_MODE:   prdata = tcbs_pkg::DATA_W'(mode_r);
      tcbs_pkg::REG_CHUNK_TARGET: prdata = tcbs_pkg::DATA_W'(target_r);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.split_mode   = mode_r;
  assign cfg.chunk_target = target_r;

endmodule

// File: rtl/core/tcbs_engine.sv
// tcbs_engine: input register plus the per-byte cut logic for code and prose modes
// depends on tcbs_pkg and tcbs_if; emits up to three results per byte

module tcbs_engine #(
  parameter int LOOKBACK_WINDOW = tcbs_pkg::LOOKBACK_WINDOW_DEF,
  parameter int DEPTH_BITS      = tcbs_pkg::DEPTH_BITS_DEF,
  parameter int POSITION_BITS   = tcbs_pkg::POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tcbs_in_if.sink                in_ch,
  input  tcbs_pkg::cfg_t         cfg,
  input  logic                   room,
  output tcbs_pkg::result_set_t  res_set,
  output tcbs_pkg::stage_status_t status
);

  localparam int PW = POSITION_BITS;
  localparam int CW = (PW > tcbs_pkg::LEN_W) ? PW : tcbs_pkg::LEN_W;

  // input register
  logic                        stg_valid_r;
  logic [tcbs_pkg::BYTE_W-1:0] stg_byte_r;
  logic                        stg_end_r;
  logic                        accept;
  logic                        advance;

  // per-text state
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [PW-1:0]               start_r, start_nxt;
  logic [DEPTH_BITS-1:0]       depth_r, depth_nxt;
  logic [PW-1:0]               nl_pos_r, nl_pos_nxt;
  logic                        nl_seen_r, nl_seen_nxt;
  logic [tcbs_pkg::BYTE_W-1:0] held_byte_r, held_byte_nxt;
  logic                        held_valid_r, held_valid_nxt;

  // shared terms
  logic [tcbs_pkg::BYTE_W-1:0] c;
  logic [PW-1:0]               i_plus1;
  logic [CW-1:0]               t1, t_half, t2, t3;

  // code mode
  logic [DEPTH_BITS-1:0]       depth_code;
  logic                        is_nl;
  logic [PW-1:0]               nl_pos_code;
  logic                        nl_seen_code;
  logic [PW-1:0]               cur, back;
  logic                        nl_cut, hard_cut, lb_ok, code_cut;
  logic [PW-1:0]               code_len, code_start;

  // prose mode
  logic [PW-1:0]               cur1, len1, s1, cur2, len2, s2;
  logic                        dbl_nl, sentence, cut1, eat, cut2;

  // wrap-up
  logic [PW-1:0]               s_fin, rem_len;
  logic                        rem_v;
  logic [tcbs_pkg::MAX_RESULTS-1:0] v, lst;
  logic [PW-1:0]               r_start [tcbs_pkg::MAX_RESULTS];
  logic [PW-1:0]               r_len   [tcbs_pkg::MAX_RESULTS];

  assign advance     = stg_valid_r && room;
  assign in_ch.ready = !stg_valid_r || room;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (accept) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte_r <= in_ch.text_byte;
      stg_end_r  <= in_ch.end_of_text;
    end
  end

  assign c       = stg_byte_r;
  assign i_plus1 = pos_r + PW'(1);
  assign t1      = CW'(cfg.chunk_target);
  assign t_half  = CW'(cfg.chunk_target >> 1);
  assign t2      = CW'({cfg.chunk_target, 1'b0});
  assign t3      = t2 + t1;

  // code mode: brace depth, newline tracking, cut at newline or at twice the target
  always_comb begin
    depth_code = depth_r;
    if (c == tcbs_pkg::CH_LBRACE && depth_r != '1) begin
      depth_code = depth_r + DEPTH_BITS'(1);
    end else if (c == tcbs_pkg::CH_RBRACE && depth_r != '0) begin
      depth_code = depth_r - DEPTH_BITS'(1);
    end
    is_nl        = (c == tcbs_pkg::CH_NL);
    nl_pos_code  = is_nl ? pos_r : nl_pos_r;
    nl_seen_code = is_nl || nl_seen_r;
    cur          = pos_r - start_r;
    back         = pos_r - nl_pos_code;
    nl_cut       = is_nl && (depth_code == '0) && (CW'(cur) > t_half);
    hard_cut     = CW'(cur) >= t2;
    lb_ok        = nl_seen_code && (back < cur) && (CW'(back) < CW'(LOOKBACK_WINDOW));
    code_cut     = nl_cut || hard_cut;
    if (nl_cut) begin
      code_len   = cur + PW'(1);
      code_start = i_plus1;
    end else if (hard_cut && lb_ok) begin
      code_len   = nl_pos_code - start_r + PW'(1);
      code_start = nl_pos_code + PW'(1);
    end else if (hard_cut) begin
      code_len   = cur;
      code_start = pos_r;
    end else begin
      code_len   = cur;
      code_start = start_r;
    end
  end

  // prose mode: judge the held byte with this byte as lookahead, then the last byte alone
  // a cut at the held byte reopens at this byte, or one past it for a swallowed newline
  always_comb begin
    cur1     = cur - PW'(1);
    dbl_nl   = (held_byte_r == tcbs_pkg::CH_NL) && (c == tcbs_pkg::CH_NL);
    sentence = tcbs_pkg::is_end_mark(held_byte_r)
               && (c == tcbs_pkg::CH_SPACE || c == tcbs_pkg::CH_NL);
    cut1     = held_valid_r && (CW'(cur1) >= t1)
               && (dbl_nl || sentence || CW'(cur1) >= t3);
    eat      = cut1 && dbl_nl;
    len1     = cur + PW'(eat);
    s1       = !cut1 ? start_r : (eat ? i_plus1 : pos_r);
    cur2     = cut1 ? '0 : cur;
    cut2     = stg_end_r && !eat && (CW'(cur2) >= t1) && (CW'(cur2) >= t3);
    len2     = cur2 + PW'(1);
    s2       = cut2 ? i_plus1 : s1;
  end

  // result slots in order: mid-text cut, last-byte prose cut, remainder
  always_comb begin
    s_fin   = cfg.split_mode ? code_start : s2;
    rem_v   = stg_end_r && (s_fin != i_plus1);
    rem_len = i_plus1 - s_fin;

    v[0] = cfg.split_mode ? code_cut : cut1;
    v[1] = !cfg.split_mode && cut2;
    v[2] = rem_v;
    r_start[0] = start_r;
    r_len[0]   = cfg.split_mode ? code_len : len1;
    r_start[1] = s1;
    r_len[1]   = len2;
    r_start[2] = s_fin;
    r_len[2]   = rem_len;

    lst[2] = v[2];
    lst[1] = v[1] && !v[2];
    lst[0] = v[0] && !v[1] && !v[2];

    for (int k = 0; k < tcbs_pkg::MAX_RESULTS; k++) begin
      res_set.vld[k]              = advance && v[k];
      res_set.res[k].chunk_start  = tcbs_pkg::START_W'(r_start[k]);
      res_set.res[k].chunk_length = tcbs_pkg::LEN_W'(r_len[k]);
      res_set.res[k].final_chunk  = stg_end_r && lst[k];
      res_set.res[k].last_of_run  = lst[k];
    end
  end

  // next state
  always_comb begin
    pos_nxt        = i_plus1;
    start_nxt      = s_fin;
    depth_nxt      = cfg.split_mode ? depth_code : depth_r;
    nl_pos_nxt     = cfg.split_mode ? nl_pos_code : nl_pos_r;
    nl_seen_nxt    = cfg.split_mode ? nl_seen_code : nl_seen_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = 1'b0;
    if (!cfg.split_mode && !eat) begin
      held_byte_nxt  = c;
      held_valid_nxt = 1'b1;
    end
    if (stg_end_r) begin
      pos_nxt        = '0;
      start_nxt      = '0;
      depth_nxt      = '0;
      nl_pos_nxt     = '0;
      nl_seen_nxt    = 1'b0;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      start_r      <= '0;
      depth_r      <= '0;
      nl_pos_r     <= '0;
      nl_seen_r    <= 1'b0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
    end else if (advance) begin
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      depth_r      <= depth_nxt;
      nl_pos_r     <= nl_pos_nxt;
      nl_seen_r    <= nl_seen_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  assign status.stage_valid = stg_valid_r;
  assign status.advance     = advance;

endmodule

// File: rtl/core/tcbs_result_fifo.sv
// tcbs_result_fifo: small register queue taking up to three results a cycle, one out
// depends on tcbs_pkg and tcbs_if

module tcbs_result_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcbs_pkg::result_set_t wr_set,
  output logic                  room,
  tcbs_out_if.source            out_ch
);

  localparam int DEPTH = tcbs_pkg::FIFO_DEPTH;
  localparam int NRES  = tcbs_pkg::MAX_RESULTS;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcbs_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0]  rd_ptr_r, wr_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  n_wr;
  logic [PTR_W-1:0]  off [NRES];
  logic              pop;
  tcbs_pkg::result_t head;

  assign pop = out_ch.valid && out_ch.ready;

  // slot offsets so that valid results land back to back
  always_comb begin
    n_wr = '0;
    for (int k = 0; k < NRES; k++) begin
      off[k] = PTR_W'(n_wr);
      n_wr   = n_wr + CNT_W'(wr_set.vld[k]);
    end
  end

  // room for a worst-case byte once this cycle's pop has left
  assign room = ({1'b0, cnt_r} <= (CNT_W + 1)'(DEPTH - NRES) + (CNT_W + 1)'(pop));

  always_ff @(posedge clk) begin
    for (int k = 0; k < NRES; k++) begin
      if (wr_set.vld[k]) begin
        mem_r[PTR_W'(wr_ptr_r + off[k])] <= wr_set.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_wr);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + n_wr - CNT_W'(pop);
    end
  end

  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.chunk_start  = head.chunk_start;
  assign out_ch.chunk_length = head.chunk_length;
  assign out_ch.final_chunk  = head.final_chunk;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule

// File: rtl/core/text_chunk_boundary_splitter_top.sv
// text chunk boundary splitter, top level. a transferred byte is held in the input register
// and its results enter the result queue as it advances. throughput: one byte per cycle; the
// byte in the input register waits until the result queue has room for three results, so
// bytes that each cause several results slow to the drain rate of one result per cycle.
// synchronous active-low reset empties the input register and result queue, clears all
// text state and loads split_mode 0, target 512.
// depends on tcbs_pkg, tcbs_if, tcbs_cfg_regs, tcbs_engine, tcbs_result_fifo

module text_chunk_boundary_splitter_top #(
  parameter int LOOKBACK_WINDOW = tcbs_pkg::LOOKBACK_WINDOW_DEF,
  parameter int DEPTH_BITS      = tcbs_pkg::DEPTH_BITS_DEF,
  parameter int POSITION_BITS   = tcbs_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte stream in, chunk results out
  tcbs_in_if.sink                     in_if,
  tcbs_out_if.source                  out_if,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcbs_pkg::ADDR_W-1:0] paddr,
  input  logic [tcbs_pkg::DATA_W-1:0] pwdata,
  output logic [tcbs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  tcbs_pkg::cfg_t          cfg;
  tcbs_pkg::result_set_t   res_set;
  tcbs_pkg::stage_status_t eng_status;
  logic                    fifo_room;

  // register file: mode and target size; write only while idle, the block does not enforce it
  tcbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register and cut logic; the per-text state updates once per byte, and the
  // latest newline offset stands in for a backward scan over the lookback window
  tcbs_engine #(
    .LOOKBACK_WINDOW (LOOKBACK_WINDOW),
    .DEPTH_BITS      (DEPTH_BITS),
    .POSITION_BITS   (POSITION_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .cfg     (cfg),
    .room    (fifo_room),
    .res_set (res_set),
    .status  (eng_status)
  );

  // result queue decouples the output side; a single waiting result does not block input
  tcbs_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_set (res_set),
    .room   (fifo_room),
    .out_ch (out_if)
  );

  // a byte transfer always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> eng_status.stage_valid)
    else $error("input transfer did not load the input register");

  // results are only written when the queue has room for a whole byte's worth
  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res_set.vld != '0) |-> fifo_room && eng_status.advance)
    else $error("results written without queue room");

  // the final chunk of a text closes its run
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.final_chunk |-> out_if.last_of_run)
    else $error("final chunk not marked last of run");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

endmodule

// File: sim/tb.sv
// tb: self-checking testbench for text_chunk_boundary_splitter_top, prose and code modes
// depends on tcbs_pkg, tcbs_if and the block's top level; no files, no arguments

module tb;

  localparam int POS_W         = tcbs_pkg::POSITION_BITS_DEF;
  localparam int DEP_W         = tcbs_pkg::DEPTH_BITS_DEF;
  localparam int LOOKBACK      = tcbs_pkg::LOOKBACK_WINDOW_DEF;
  localparam int SETTLE_CYCLES = 8;        // margin after the last owed result arrives
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_SHOWN     = 10;
  localparam int LONG_HOLD     = 400;      // receiver hold-off to back up the input
  localparam int N_PHASES      = 8;
  localparam int LONG_TARGET   = 104;      // 2T just past the lookback window

  // random phases: mode and target per phase
  localparam int PHASE_MODE   [N_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
  localparam int PHASE_TARGET [N_PHASES] = '{3, 0, 6, LONG_TARGET, 1, 65535, 2, 4};

  typedef enum logic [1:0] {ROW_BYTE, ROW_SET_MODE, ROW_SET_TARGET} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [15:0]       value;
    logic              eot;
    logic              typed;    // want holds the single expected chunk
    tcbs_pkg::result_t want;
  } stim_row_t;

  localparam tcbs_pkg::result_t NO_WANT  = '0;
  localparam tcbs_pkg::result_t ONE_BYTE = '{32'd0, 18'd1, 1'b1, 1'b1};

  // directed script: reset defaults, byte extremes, brace floor, code cuts
  // (newline, lookback, forced), prose cuts (end mark, swallowed double newline,
  // last byte with no lookahead) and a mode switch with a held prose byte
  localparam int N_ROWS = 30;
  localparam stim_row_t SCRIPT [N_ROWS] = '{
    '{ROW_BYTE, 16'h00, 1'b1, 1'b1, ONE_BYTE},
    '{ROW_BYTE, 16'hFF, 1'b1, 1'b1, ONE_BYTE},
    '{ROW_SET_MODE, 16'd1, 1'b0, 1'b0, NO_WANT},
    '{ROW_SET_TARGET, 16'd0, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_LBRACE, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_RBRACE, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_RBRACE, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_NL, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "a", 1'b1, 1'b0, NO_WANT},
    '{ROW_SET_TARGET, 16'd2, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "a", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_NL, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_LBRACE, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "b", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "c", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "d", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "e", 1'b1, 1'b0, NO_WANT},
    '{ROW_SET_MODE, 16'd0, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "h", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "i", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_SPACE, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "o", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, "k", 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_NL, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_NL, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_QUEST, 1'b1, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT},
    '{ROW_SET_MODE, 16'd1, 1'b0, 1'b0, NO_WANT},
    '{ROW_BYTE, tcbs_pkg::CH_NL, 1'b1, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [tcbs_pkg::ADDR_W-1:0]   paddr;
  logic [tcbs_pkg::DATA_W-1:0]   pwdata;
  logic [tcbs_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  tcbs_in_if  in_ch ();
  tcbs_out_if out_ch ();

  text_chunk_boundary_splitter_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // chunk predictor: own copy of the registers and the per-text state
  // ---------------------------------------------------------------------------
  logic             mode_code;
  logic [15:0]      target_len;
  logic [POS_W-1:0] txt_pos;
  logic [POS_W-1:0] chunk_open;
  logic [DEP_W-1:0] brace_lvl;
  logic [POS_W-1:0] nl_at;
  logic             nl_valid;
  logic [7:0]       pend_byte;
  logic             pend_valid;

  tcbs_pkg::result_t step_out [$];     // chunks caused by the byte being predicted
  tcbs_pkg::result_t chunk_q [$];      // chunks still owed by the block

  int mismatches  = 0;
  int chunks_seen = 0;
  int bytes_sent  = 0;
  int texts_sent  = 0;
  int cycle_count = 0;

  // idling knobs, set per phase
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_request = 0;

  function automatic void clear_text();
    txt_pos    = '0;
    chunk_open = '0;
    brace_lvl  = '0;
    nl_at      = '0;
    nl_valid   = 1'b0;
    pend_byte  = '0;
    pend_valid = 1'b0;
  endfunction

  function automatic void add_chunk(input logic [POS_W-1:0] first, input logic [POS_W-1:0] n);
    tcbs_pkg::result_t r;
    r.chunk_start  = first[tcbs_pkg::START_W-1:0];
    r.chunk_length = n[tcbs_pkg::LEN_W-1:0];
    r.final_chunk  = 1'b0;
    r.last_of_run  = 1'b0;
    step_out.push_back(r);
  endfunction

  // code mode: brace depth, newline cut past T/2, lookback or forced cut at 2T
  function automatic void code_byte(input logic [7:0] c, input logic [POS_W-1:0] i);
    logic [POS_W-1:0] run_len;
    logic [POS_W-1:0] back;
    logic [31:0]      t;
    t          = 32'(target_len);
    run_len    = i - chunk_open;
    pend_valid = 1'b0;
    if (c == tcbs_pkg::CH_LBRACE) begin
      if (brace_lvl != '1) brace_lvl = brace_lvl + 1'b1;
    end else if (c == tcbs_pkg::CH_RBRACE) begin
      if (brace_lvl != '0) brace_lvl = brace_lvl - 1'b1;
    end
    if (c == tcbs_pkg::CH_NL) begin
      nl_at    = i;
      nl_valid = 1'b1;
    end
    if (c == tcbs_pkg::CH_NL && brace_lvl == '0 && run_len > t / 2) begin
      add_chunk(chunk_open, run_len + 1);
      chunk_open = i + 1;
    end else if (run_len >= 2 * t) begin
      back = i - nl_at;
      if (nl_valid && back < run_len && back < LOOKBACK) begin
        add_chunk(chunk_open, nl_at - chunk_open + 1);
        chunk_open = nl_at + 1;
      end else begin
        // cut in front of the current byte, which opens the next chunk
        add_chunk(chunk_open, run_len);
        chunk_open = i;
      end
    end
  endfunction

  // judge one prose byte; returns 1 when the lookahead byte was swallowed
  function automatic logic prose_cut(input logic [7:0] c, input logic [POS_W-1:0] at,
                                     input logic has_next, input logic [7:0] nx);
    logic [POS_W-1:0] run_len;
    logic [POS_W-1:0] n;
    logic [31:0]      t;
    logic             hit;
    logic             eat;
    t       = 32'(target_len);
    run_len = at - chunk_open;
    hit     = 1'b0;
    eat     = 1'b0;
    if (run_len < t) return 1'b0;
    if (has_next) begin
      if (c == tcbs_pkg::CH_NL && nx == tcbs_pkg::CH_NL) begin
        hit = 1'b1;
        eat = 1'b1;
      end else if ((c == tcbs_pkg::CH_DOT || c == tcbs_pkg::CH_BANG ||
                    c == tcbs_pkg::CH_QUEST) &&
                   (nx == tcbs_pkg::CH_SPACE || nx == tcbs_pkg::CH_NL)) begin
        hit = 1'b1;
      end
    end
    if (!hit && run_len < 3 * t) return 1'b0;
    n = run_len + 1 + eat;
    add_chunk(chunk_open, n);
    chunk_open = chunk_open + n;
    return eat;
  endfunction

  function automatic void prose_byte(input logic [7:0] c, input logic [POS_W-1:0] i,
                                     input logic eot);
    logic eaten;
    eaten = 1'b0;
    if (pend_valid) eaten = prose_cut(pend_byte, i - 1, 1'b1, c);
    pend_valid = 1'b0;
    if (!eaten) begin
      pend_byte  = c;
      pend_valid = 1'b1;
      // last byte has no lookahead: only the hard limit can cut here
      if (eot) void'(prose_cut(c, i, 1'b0, 8'h00));
    end
  endfunction

  function automatic void predict_chunks(input logic [7:0] c, input logic eot);
    logic [POS_W-1:0]  i;
    logic [POS_W-1:0]  rem;
    logic [POS_W-1:0]  used;
    tcbs_pkg::result_t tail;
    step_out.delete();
    i = txt_pos;
    if (mode_code) code_byte(c, i);
    else prose_byte(c, i, eot);
    if (eot) begin
      rem  = i + 1 - chunk_open;
      used = i - chunk_open;
      if (chunk_open != i + 1 && used < rem) add_chunk(chunk_open, rem);
      if (step_out.size() > 0) begin
        tail = step_out.pop_back();
        tail.final_chunk = 1'b1;
        step_out.push_back(tail);
      end
      clear_text();
    end else begin
      txt_pos = i + 1;
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.last_of_run = 1'b1;
      step_out.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch: %s", what);
  endfunction

  function automatic void check_chunk();
    tcbs_pkg::result_t want;
    chunks_seen++;
    if (chunk_q.size() == 0) begin
      flag_mismatch($sformatf("chunk %0d (start %0d len %0d) with none expected",
                              chunks_seen, out_ch.chunk_start, out_ch.chunk_length));
      return;
    end
    want = chunk_q.pop_front();
    if (out_ch.chunk_start !== want.chunk_start)
      flag_mismatch($sformatf("chunk %0d start: expected %0d, got %0d",
                              chunks_seen, want.chunk_start, out_ch.chunk_start));
    if (out_ch.chunk_length !== want.chunk_length)
      flag_mismatch($sformatf("chunk %0d length: expected %0d, got %0d",
                              chunks_seen, want.chunk_length, out_ch.chunk_length));
    if (out_ch.final_chunk !== want.final_chunk)
      flag_mismatch($sformatf("chunk %0d final_chunk: expected %0b, got %0b",
                              chunks_seen, want.final_chunk, out_ch.final_chunk));
    if (out_ch.last_of_run !== want.last_of_run)
      flag_mismatch($sformatf("chunk %0d last_of_run: expected %0b, got %0b",
                              chunks_seen, want.last_of_run, out_ch.last_of_run));
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one byte, wait for its transfer, then book the chunks it causes
  task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                           input tcbs_pkg::result_t want);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer happened at this edge
    bytes_sent++;
    if (eot) texts_sent++;
    predict_chunks(c, eot);
    if (typed) chunk_q.push_back(want);
    else foreach (step_out[k]) chunk_q.push_back(step_out[k]);
  endtask

  // stop offering, let every owed chunk arrive, then allow for in-flight work
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write (setup + access) followed by a read back of the same register
  task automatic write_reg(input logic [tcbs_pkg::REG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    logic [tcbs_pkg::DATA_W-1:0] word;
    word    = (idx == tcbs_pkg::REG_SPLIT_MODE) ? tcbs_pkg::DATA_W'(value[0])
                                                : tcbs_pkg::DATA_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tcbs_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== word)
      flag_mismatch($sformatf("register %0d read back: expected %0d, got %0d",
                              idx, word, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == tcbs_pkg::REG_SPLIT_MODE) mode_code = value[0];
    else target_len = value;
  endtask

  // text-like bytes: words, spaces, end marks, newlines, braces and raw noise
  function automatic logic [7:0] pick_char(input int nl_w, input logic [7:0] prev);
    int r;
    if ((prev == tcbs_pkg::CH_DOT || prev == tcbs_pkg::CH_BANG ||
         prev == tcbs_pkg::CH_QUEST) && $urandom_range(0, 1))
      return $urandom_range(0, 3) == 0 ? tcbs_pkg::CH_NL : tcbs_pkg::CH_SPACE;
    r = $urandom_range(0, 99);
    if (r < nl_w) return tcbs_pkg::CH_NL;
    r -= nl_w;
    if (r < 10) return tcbs_pkg::CH_SPACE;
    if (r < 18) return tcbs_pkg::CH_LBRACE;
    if (r < 26) return tcbs_pkg::CH_RBRACE;
    if (r < 32) return tcbs_pkg::CH_DOT;
    if (r < 35) return tcbs_pkg::CH_BANG;
    if (r < 38) return tcbs_pkg::CH_QUEST;
    if (r < 46) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: checks every transfer, stalls at random or for a long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_chunk();
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chunks still owed", cycle_count, chunk_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] c;
    logic [7:0] prev;
    int         text_left;
    int         budget;
    idle_mode_e idle;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    mode_code  = 1'b0;
    target_len = tcbs_pkg::TARGET_RESET;
    clear_text();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script, no idling
    for (int r = 0; r < N_ROWS; r++) begin
      case (SCRIPT[r].kind)
        ROW_BYTE: begin
          send_byte(SCRIPT[r].value[7:0], SCRIPT[r].eot, SCRIPT[r].typed, SCRIPT[r].want);
        end
        ROW_SET_MODE: begin
          settle_block();
          write_reg(tcbs_pkg::REG_SPLIT_MODE, SCRIPT[r].value);
        end
        default: begin
          settle_block();
          write_reg(tcbs_pkg::REG_CHUNK_TARGET, SCRIPT[r].value);
        end
      endcase
    end

    // random phases; a text may run across a phase, so modes also change mid-text
    text_left = 0;
    prev      = 8'h00;
    for (int p = 0; p < N_PHASES; p++) begin
      settle_block();
      idle = idle_mode_e'(p % 4);
      case (idle)
        IDLE_NONE: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        IDLE_SENDER: begin
          gap_pct   = 67;
          stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          gap_pct   = 0;
          stall_pct = 67;
        end
        default: begin
          gap_pct   = 20;
          stall_pct = 20;
        end
      endcase
      write_reg(tcbs_pkg::REG_SPLIT_MODE, 16'(PHASE_MODE[p]));
      write_reg(tcbs_pkg::REG_CHUNK_TARGET, 16'(PHASE_TARGET[p]));
      // long hold-off: the result queue fills and the input backs up
      if (p == 0) hold_request = LONG_HOLD;
      budget = (PHASE_TARGET[p] == LONG_TARGET) ? 250 : 33;
      for (int k = 0; k < budget; k++) begin
        if (text_left == 0) begin
          if (PHASE_TARGET[p] == LONG_TARGET) text_left = $urandom_range(210, 320);
          else if ($urandom_range(0, 3) == 0) text_left = $urandom_range(1, 3);
          else text_left = $urandom_range(4, 40);
        end
        c = pick_char((PHASE_TARGET[p] == LONG_TARGET) ? 1 : 12, prev);
        send_byte(c, text_left == 1, 1'b0, NO_WANT);
        prev = c;
        text_left--;
      end
    end

    settle_block();
    $display("covered %0d bytes in %0d complete texts, %0d chunks checked", bytes_sent,
             texts_sent, chunks_seen);
    $display("prose and code modes, targets 0 to 65535, mid-text mode switches, long hold-off");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
